### sv/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

  localparam int ANGLE_W     = 16;
  localparam int COUNT_W     = 4;
  localparam int OUT_W       = 24;
  localparam int TERM_W      = 34;
  localparam int SUM_W       = 40;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 30;

  localparam int MAX_TERMS_DEF = 12;
  localparam int FRAC_BITS_DEF = 13;

  localparam longint TERM_LIM = 64'sd8589934591;
  localparam longint OUT_MAX  = 64'sd8388607;
  localparam longint OUT_MIN  = -64'sd8388608;

  // 2^30 / ((2k+2)(2k+3)), rounded, for the step from term k to term k+1
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] k);
    logic [RECIP_W-1:0] r;
    unique case (k)
      4'd0:    r = 28'd178956971;
      4'd1:    r = 28'd53687091;
      4'd2:    r = 28'd25565282;
      4'd3:    r = 28'd14913081;
      4'd4:    r = 28'd9761289;
      4'd5:    r = 28'd6882960;
      4'd6:    r = 28'd5113056;
      4'd7:    r = 28'd3947580;
      4'd8:    r = 28'd3139596;
      4'd9:    r = 28'd2556528;
      4'd10:   r = 28'd2122019;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/sts_step.sv
`timescale 1ns / 1ps

module sts_step #(
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               src_valid,
  output logic                               src_ready,
  input  logic signed [sts_pkg::TERM_W-1:0]  src_term,
  input  logic        [30-FRAC_BITS:0]       src_x2,
  input  logic signed [sts_pkg::SUM_W-1:0]   src_sum,
  input  logic        [sts_pkg::COUNT_W-1:0] src_count,
  output logic                               dst_valid,
  input  logic                               dst_ready,
  output logic signed [sts_pkg::TERM_W-1:0]  dst_term,
  output logic        [30-FRAC_BITS:0]       dst_x2,
  output logic signed [sts_pkg::SUM_W-1:0]   dst_sum,
  output logic        [sts_pkg::COUNT_W-1:0] dst_count
);
  import sts_pkg::*;

  localparam int X2_W = 31 - FRAC_BITS;
  localparam int W1   = TERM_W + X2_W + 1;
  localparam int W2   = TERM_W + RECIP_W + 1;

  localparam logic signed [W1-1:0] HALF1 = W1'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [W1-1:0] LIM1  = W1'(TERM_LIM);
  localparam logic signed [W2-1:0] HALF2 = W2'(64'd1 << (RECIP_SHIFT - 1));
  localparam logic signed [W2-1:0] LIM2  = W2'(TERM_LIM);
  localparam logic [RECIP_W-1:0]   RECIP_K = recip(COUNT_W'(STEP));

  // four stages: multiply by x^2, round, multiply by reciprocal, round and negate
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  logic signed [W1-1:0]     s1_prod;
  logic signed [SUM_W-1:0]  s1_sum;
  logic [X2_W-1:0]          s1_x2;
  logic [COUNT_W-1:0]       s1_count;

  logic signed [TERM_W-1:0] s2_p;
  logic signed [SUM_W-1:0]  s2_sum;
  logic [X2_W-1:0]          s2_x2;
  logic [COUNT_W-1:0]       s2_count;

  logic signed [W2-1:0]     s3_prod;
  logic signed [SUM_W-1:0]  s3_sum;
  logic [X2_W-1:0]          s3_x2;
  logic [COUNT_W-1:0]       s3_count;

  logic signed [TERM_W-1:0] s4_term;
  logic signed [SUM_W-1:0]  s4_sum;
  logic [X2_W-1:0]          s4_x2;
  logic [COUNT_W-1:0]       s4_count;

  logic signed [W1-1:0]     prod1_next;
  logic signed [SUM_W-1:0]  sum1_next;
  logic signed [W1-1:0]     adj1, rnd1;
  logic signed [TERM_W-1:0] p_next;
  logic signed [W2-1:0]     prod2_next;
  logic signed [W2-1:0]     adj2, rnd2;
  logic signed [TERM_W-1:0] term_next;

  assign r4 = !v4 || dst_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign src_ready = r1;

  always_comb begin
    prod1_next = W1'(src_term) * W1'($signed({1'b0, src_x2}));
    sum1_next  = src_sum + ((COUNT_W'(STEP) < src_count) ? SUM_W'(src_term) : '0);

    // round to nearest, ties away from zero: bias down by one when negative
    adj1 = s1_prod + HALF1 - $signed(W1'(s1_prod[W1-1]));
    rnd1 = adj1 >>> FRAC_BITS;
    if (rnd1 > LIM1) begin
      p_next = TERM_W'(LIM1);
    end else if (rnd1 < -LIM1) begin
      p_next = TERM_W'(-LIM1);
    end else begin
      p_next = TERM_W'(rnd1);
    end

    prod2_next = W2'(s2_p) * W2'($signed({1'b0, RECIP_K}));

    adj2 = s3_prod + HALF2 - $signed(W2'(s3_prod[W2-1]));
    rnd2 = adj2 >>> RECIP_SHIFT;
    if (rnd2 > LIM2) begin
      term_next = TERM_W'(-LIM2);
    end else if (rnd2 < -LIM2) begin
      term_next = TERM_W'(LIM2);
    end else begin
      term_next = TERM_W'(-rnd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= src_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_prod  <= prod1_next;
      s1_sum   <= sum1_next;
      s1_x2    <= src_x2;
      s1_count <= src_count;
    end
    if (r2) begin
      s2_p     <= p_next;
      s2_sum   <= s1_sum;
      s2_x2    <= s1_x2;
      s2_count <= s1_count;
    end
    if (r3) begin
      s3_prod  <= prod2_next;
      s3_sum   <= s2_sum;
      s3_x2    <= s2_x2;
      s3_count <= s2_count;
    end
    if (r4) begin
      s4_term  <= term_next;
      s4_sum   <= s3_sum;
      s4_x2    <= s3_x2;
      s4_count <= s3_count;
    end
  end

  assign dst_valid = v4;
  assign dst_term  = s4_term;
  assign dst_x2    = s4_x2;
  assign dst_sum   = s4_sum;
  assign dst_count = s4_count;

endmodule

### sv/sine_taylor_series.sv
// Throughput: one beat per cycle while result_ready is not holding the pipe; each
// series term after the first takes four register stages (multiply by x^2, round,
// multiply by reciprocal, round).
// Each stage stalls only when the one after it is full and stalled.
// Reset (rst, synchronous) clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps

module sine_taylor_series #(
  parameter int MAX_TERMS = sts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic signed [sts_pkg::ANGLE_W-1:0] angle,
  input  logic        [sts_pkg::COUNT_W-1:0] term_count,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [sts_pkg::OUT_W-1:0]   series_value,
  output logic                               saturated
);
  import sts_pkg::*;

  localparam int NSTEP = MAX_TERMS - 1;
  localparam int X2_W  = 31 - FRAC_BITS;
  localparam int SQ_W  = 2 * ANGLE_W;

  localparam logic [SQ_W:0]             HALF0   = (SQ_W + 1)'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0]   SUM_MAX = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0]   SUM_MIN = SUM_W'(OUT_MIN);

  // entry stage: x^2 rounded to FRAC_BITS
  logic                     v0;
  logic                     r0;
  logic signed [TERM_W-1:0] term0;
  logic [X2_W-1:0]          x20;
  logic [COUNT_W-1:0]       count0;

  logic signed [SQ_W-1:0]   sq;
  logic [SQ_W:0]            sq_r;
  logic [X2_W-1:0]          x2_next;

  logic                     link_valid [0:NSTEP];
  logic                     link_ready [0:NSTEP];
  logic signed [TERM_W-1:0] link_term  [0:NSTEP];
  logic [X2_W-1:0]          link_x2    [0:NSTEP];
  logic signed [SUM_W-1:0]  link_sum   [0:NSTEP];
  logic [COUNT_W-1:0]       link_count [0:NSTEP];

  logic signed [SUM_W-1:0]  total;
  logic signed [OUT_W-1:0]  value_next;
  logic                     sat_next;

  always_comb begin
    sq      = SQ_W'(angle) * SQ_W'(angle);
    sq_r    = {1'b0, $unsigned(sq)} + HALF0;
    x2_next = X2_W'(sq_r >> FRAC_BITS);
  end

  assign r0         = !v0 || link_ready[0];
  assign item_ready = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r0) begin
      term0  <= TERM_W'(angle);
      x20    <= x2_next;
      count0 <= term_count;
    end
  end

  assign link_valid[0] = v0;
  assign link_term[0]  = term0;
  assign link_x2[0]    = x20;
  assign link_sum[0]   = '0;
  assign link_count[0] = count0;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    sts_step #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (g)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .src_valid (link_valid[g]),
      .src_ready (link_ready[g]),
      .src_term  (link_term[g]),
      .src_x2    (link_x2[g]),
      .src_sum   (link_sum[g]),
      .src_count (link_count[g]),
      .dst_valid (link_valid[g+1]),
      .dst_ready (link_ready[g+1]),
      .dst_term  (link_term[g+1]),
      .dst_x2    (link_x2[g+1]),
      .dst_sum   (link_sum[g+1]),
      .dst_count (link_count[g+1])
    );
  end

  // last term joins the sum here, then the result is clipped
  always_comb begin
    total = link_sum[NSTEP] +
            ((COUNT_W'(MAX_TERMS - 1) < link_count[NSTEP]) ? SUM_W'(link_term[NSTEP]) : '0);
    if (total > SUM_MAX) begin
      value_next = OUT_W'(SUM_MAX);
      sat_next   = 1'b1;
    end else if (total < SUM_MIN) begin
      value_next = OUT_W'(SUM_MIN);
      sat_next   = 1'b1;
    end else begin
      value_next = OUT_W'(total);
      sat_next   = 1'b0;
    end
  end

  assign link_ready[NSTEP] = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (link_ready[NSTEP]) begin
      result_valid <= link_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (link_ready[NSTEP]) begin
      series_value <= value_next;
      saturated    <= sat_next;
    end
  end

  // a clipped result sits on one of the two limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      (series_value == OUT_W'(SUM_MAX)) || (series_value == OUT_W'(SUM_MIN)))
    else $error("saturated result not at a limit");

  // the entry only stalls when the whole pipe is full behind a held result
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("entry stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  // the last link's x^2 is not used further; keep it tied to the pipe for checking
  a_x2_range: assert property (@(posedge clk) disable iff (rst)
    link_valid[NSTEP] |-> link_x2[NSTEP] <= X2_W'(64'd1 << (30 - FRAC_BITS)))
    else $error("x^2 beyond its range");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL  = 150;   // beats at the end with no idling on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, well past the pipe depth
  localparam int HOLD_AT     = 600;   // clear of the points where the sender waits for a drain
  localparam int N_RANDOM    = 1550;
  localparam int REPORT_CAP  = 100;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic        [COUNT_W-1:0] count;
    bit                        wait_drain;
    int                        idle_pct;
  } sine_job_t;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } series_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_ready;
  logic signed [ANGLE_W-1:0] angle = '0;
  logic        [COUNT_W-1:0] term_count = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [OUT_W-1:0]   series_value;
  logic                      saturated;

  sine_job_t sine_jobs[$];
  series_t   expected_sums[$];
  int        n_jobs;
  int        n_sent;
  int        n_got;
  int        errors;
  int        cycles;
  int        send_gap;
  int        hold_left;
  bit        hold_done;
  int        ready_pct;

  sine_taylor_series u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .angle        (angle),
    .term_count   (term_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .series_value (series_value),
    .saturated    (saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // divide by 2^s, nearest, ties away from zero
  function automatic longint round_div_pow2(longint v, int s);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clip_term(longint v);
    if (v > TERM_LIM) return TERM_LIM;
    if (v < -TERM_LIM) return -TERM_LIM;
    return v;
  endfunction

  // 2^30 / ((2k+2)(2k+3)) rounded; the divisor is always even so d/2 is exact
  function automatic longint term_recip(int k);
    longint d;
    d = longint'(2 * k + 2) * longint'(2 * k + 3);
    return ((64'sd1 <<< RECIP_SHIFT) + d / 2) / d;
  endfunction

  function automatic series_t sine_series(logic signed [ANGLE_W-1:0] a,
                                          logic [COUNT_W-1:0] n);
    longint  x;
    longint  x2;
    longint  term;
    longint  p;
    longint  sum;
    int      terms;
    series_t r;
    x     = a;
    terms = (n > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(n);
    x2    = round_div_pow2(x * x, FRAC_BITS_DEF);
    term  = x;
    sum   = 0;
    for (int k = 0; k < terms; k++) begin
      sum += term;
      if (k + 1 < terms) begin
        p    = clip_term(round_div_pow2(term * x2, FRAC_BITS_DEF));
        term = -clip_term(round_div_pow2(p * term_recip(k), RECIP_SHIFT));
      end
    end
    r.sat = 1'b0;
    if (sum > OUT_MAX) begin
      sum   = OUT_MAX;
      r.sat = 1'b1;
    end else if (sum < OUT_MIN) begin
      sum   = OUT_MIN;
      r.sat = 1'b1;
    end
    r.value = sum[OUT_W-1:0];
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    sine_job_t job;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (item_valid && item_ready) begin
        expected_sums.push_back(sine_series(angle, term_count));
        n_sent++;
      end
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          item_valid <= 1'b0;
        end else if (sine_jobs.size() == 0 ||
                     (sine_jobs[0].wait_drain && expected_sums.size() != 0)) begin
          item_valid <= 1'b0;
        end else if (sine_jobs[0].idle_pct != 0 &&
                     $urandom_range(99) < sine_jobs[0].idle_pct) begin
          send_gap   <= $urandom_range(12, 1) - 1;
          item_valid <= 1'b0;
        end else begin
          job        = sine_jobs.pop_front();
          item_valid <= 1'b1;
          angle      <= job.angle;
          term_count <= job.count;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    series_t want;
    if (rst) begin
      result_ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (result_valid && result_ready) begin
        n_got++;
        if (expected_sums.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected result beat: expected none, actual %0d sat %0b",
                     $time, series_value, saturated);
        end else begin
          want = expected_sums.pop_front();
          if (series_value !== want.value) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: series_value mismatch: expected %0d, actual %0d",
                       $time, want.value, series_value);
          end
          if (saturated !== want.sat) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: saturated mismatch: expected %0b, actual %0b",
                       $time, want.sat, saturated);
          end
        end
        if (n_got % 64 == 0) begin
          case ($urandom_range(2))
            0:       ready_pct = 0;
            1:       ready_pct = 15;
            default: ready_pct = 50;
          endcase
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (!hold_done && n_got >= HOLD_AT) begin
        // long hold-off so the pipe fills and back-pressures the input
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES - 1;
        result_ready <= 1'b0;
      end else if (n_got < n_jobs - QUIET_TAIL && ready_pct != 0 &&
                   $urandom_range(99) < ready_pct) begin
        hold_left    <= $urandom_range(12, 1) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    logic signed [ANGLE_W-1:0] edge_angles[17];
    logic        [COUNT_W-1:0] edge_counts[17];
    sine_job_t                 job;
    int                        idle_pct;
    int                        pick;

    n_sent    = 0;
    n_got     = 0;
    errors    = 0;
    cycles    = 0;
    hold_done = 1'b0;
    ready_pct = 15;

    // field extremes, zero terms, count above the maximum, quarter and half turns
    edge_angles = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                    16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
                    -16'sd32768, 16'sd32767, 16'sd12868, -16'sd12868, 16'sd25736,
                    -16'sd25736, 16'sd8192};
    edge_counts = '{4'd0, 4'd0, 4'd0, 4'd12, 4'd12, 4'd1, 4'd1, 4'd12, 4'd12, 4'd12,
                    4'd15, 4'd13, 4'd12, 4'd12, 4'd12, 4'd5, 4'd2};
    for (int i = 0; i < 17; i++) begin
      job.angle      = edge_angles[i];
      job.count      = edge_counts[i];
      job.wait_drain = 1'b0;
      job.idle_pct   = 0;
      sine_jobs.push_back(job);
    end

    idle_pct = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 70)
        job.angle = ANGLE_W'($urandom_range(16'hFFFF));
      else if (pick < 85)
        job.angle = ANGLE_W'($urandom_range(1) ? 16'sd32767 - $urandom_range(63)
                                               : -16'sd32768 + $urandom_range(63));
      else
        job.angle = $signed(16'($urandom_range(511))) - 16'sd256;
      job.count      = COUNT_W'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                         : $urandom_range(12));
      job.wait_drain = (i % 400 == 0);
      job.idle_pct   = (i >= N_RANDOM - QUIET_TAIL) ? 0 : idle_pct;
      sine_jobs.push_back(job);
    end
    n_jobs = sine_jobs.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (n_sent < n_jobs) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
